// File: design/nsc_pkg.sv
// Package for the NFA subset construction unit.
// Holds the item structs, request and register codes, and the controller/datapath link.
// Has no dependencies.
package nsc_pkg;

  localparam int unsigned SET_W    = 8;
  localparam int unsigned TABLE_W  = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned REQ_W    = 2;

  // Request codes of an input item.
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL   = 3'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SET_W-1:0] query_set;
  } nsc_req_t;

  typedef struct packed {
    logic             row_valid;
    logic [SET_W-1:0] state_set;
    logic [SET_W-1:0] next_on_a;
    logic [SET_W-1:0] next_on_b;
    logic             is_start;
    logic             is_final;
    logic             last;
    logic [SET_W-1:0] dfa_number;
  } nsc_res_t;

  // Which kind of result the datapath assembles.
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_ROW,
    RES_QUERY
  } nsc_kind_e;

  typedef struct packed {
    logic      restart;
    logic      pop;
    logic      expand;
    logic      push_a;
    logic      push_b;
    logic      q_clear;
    logic      q_step;
    logic      res_load;
    nsc_kind_e res_kind;
  } nsc_cmd_t;

  typedef struct packed {
    logic wl_empty;
    logic chunk_last;
  } nsc_status_t;

  // Mask of the singleton subset holding one NFA state.
  function automatic logic [SET_W-1:0] single_set(input logic [2:0] state);
    single_set = 8'h80 >> state;
  endfunction

endpackage

// File: design/nsc_ctrl.sv
// Controller state machine of the NFA subset construction unit.
// Sequences restart, step and query items; depends on nsc_pkg.
module nsc_ctrl
  import nsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  nsc_status_t          status_i,
  output nsc_cmd_t             cmd_o,
  output logic                 busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_QUERY,
    ST_FINISH
  } state_e;

  state_e    state_q, state_d;
  nsc_kind_e kind_q, kind_d;
  logic      busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    kind_d  = kind_q;
    busy_d  = busy_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          busy_d = 1'b1;
          case (req_type_i)
            REQ_RESTART: begin
              cmd_o.restart = 1'b1;
              kind_d        = RES_PLAIN;
              state_d       = ST_FINISH;
            end
            REQ_STEP: begin
              if (status_i.wl_empty) begin
                kind_d  = RES_PLAIN;
                state_d = ST_FINISH;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = ST_EXPAND;
              end
            end
            REQ_QUERY: begin
              cmd_o.q_clear = 1'b1;
              state_d       = ST_QUERY;
            end
            default: begin
              kind_d  = RES_PLAIN;
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_EXPAND: begin
        cmd_o.expand = 1'b1;
        state_d      = ST_PUSH_A;
      end
      ST_PUSH_A: begin
        cmd_o.push_a = 1'b1;
        state_d      = ST_PUSH_B;
      end
      ST_PUSH_B: begin
        cmd_o.push_b = 1'b1;
        kind_d       = RES_ROW;
        state_d      = ST_FINISH;
      end
      ST_QUERY: begin
        cmd_o.q_step = 1'b1;
        if (status_i.chunk_last) begin
          kind_d  = RES_QUERY;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = kind_q;
        busy_d         = 1'b0;
        state_d        = ST_IDLE;
      end
      default: begin
        busy_d  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_PLAIN;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// File: design/nsc_dpath.sv
// Datapath of the NFA subset construction unit: configuration, discovered map,
// worklist memory, successor logic, rank counter and result register; uses nsc_pkg.
module nsc_dpath
  import nsc_pkg::*;
#(
  parameter int unsigned NFA_STATES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TABLE_W-1:0]   cfg_wdata_i,
  input  logic [SET_W-1:0]     query_set_i,
  input  nsc_cmd_t             cmd_i,
  output nsc_status_t          status_o,
  output nsc_res_t             result_o,
  output logic                 result_valid_o
);

  localparam int unsigned Subsets = 1 << SET_W;
  localparam int unsigned CntW    = SET_W + 1;
  localparam int unsigned ChunkW  = SET_W - 3;

  logic [TABLE_W-1:0] trans_a_q, trans_b_q;
  logic [2:0]         start_q, final_q;

  logic [Subsets-1:0] seen_q, seen_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SET_W-1:0]   wl_mem [Subsets];
  logic [SET_W-1:0]   rd_q;
  logic               wr_en;
  logic [SET_W-1:0]   wr_addr, wr_data;

  logic [SET_W-1:0]   cur_q, na_q, nb_q, qset_q;
  logic [SET_W-1:0]   na_c, nb_c;
  logic [SET_W-1:0]   rank_q, rank_d;
  logic [ChunkW-1:0]  chunk_q;
  logic [3:0]         chunk_sum;

  nsc_res_t           result_q, result_d;
  logic               valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_a_q <= '0;
      trans_b_q <= '0;
      start_q   <= '0;
      final_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRANS_A: trans_a_q <= cfg_wdata_i;
        CFG_TRANS_B: trans_b_q <= cfg_wdata_i;
        CFG_START:   start_q   <= cfg_wdata_i[2:0];
        CFG_FINAL:   final_q   <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Successor masks of the popped subset; state i is bit 7-i.
  always_comb begin
    na_c = '0;
    nb_c = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (i < NFA_STATES && rd_q[SET_W-1-i]) begin
        na_c = na_c | trans_a_q[8*i +: SET_W];
        nb_c = nb_c | trans_b_q[8*i +: SET_W];
      end
    end
  end

  // Discovered map, worklist count and memory write port.
  always_comb begin
    seen_d  = seen_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = count_q[SET_W-1:0];
    wr_data = na_q;
    if (cmd_i.restart) begin
      seen_d  = '0;
      count_d = CntW'(1);
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = single_set(start_q);
    end
    if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.expand) begin
      seen_d[rd_q] = 1'b1;
    end
    if (cmd_i.push_a && !seen_q[na_q]) begin
      seen_d[na_q] = 1'b1;
      if (!count_q[SET_W]) begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end
    if (cmd_i.push_b && !seen_q[nb_q]) begin
      seen_d[nb_q] = 1'b1;
      wr_data      = nb_q;
      if (!count_q[SET_W]) begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wl_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.pop) begin
      rd_q <= wl_mem[count_q[SET_W-1:0] - SET_W'(1)];
    end
  end

  // Rank of the queried subset: eight map bits per cycle while q_step is high.
  always_comb begin
    logic [SET_W-1:0] idx;
    chunk_sum = '0;
    for (int k = 0; k < 8; k++) begin
      idx = {chunk_q, 3'(k)};
      if (seen_q[idx] && idx < qset_q && idx != '0) begin
        chunk_sum = chunk_sum + 4'd1;
      end
    end
    rank_d = rank_q + SET_W'(chunk_sum);
  end

  // Result assembly.
  always_comb begin
    result_d      = '0;
    result_d.last = (count_q == '0);
    case (cmd_i.res_kind)
      RES_ROW: begin
        result_d.row_valid = 1'b1;
        result_d.state_set = cur_q;
        result_d.next_on_a = na_q;
        result_d.next_on_b = nb_q;
        result_d.is_start  = (cur_q == single_set(start_q));
        result_d.is_final  = (cur_q != single_set(start_q)) &&
                             ((cur_q & single_set(final_q)) != '0);
      end
      RES_QUERY: begin
        if (qset_q != '0) begin
          result_d.row_valid  = seen_q[qset_q];
          result_d.state_set  = qset_q;
          result_d.is_start   = (qset_q == single_set(start_q));
          result_d.is_final   = (qset_q != single_set(start_q)) &&
                                ((qset_q & single_set(final_q)) != '0);
          result_d.dfa_number = rank_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      count_q <= '0;
      chunk_q <= '0;
      valid_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      count_q <= count_d;
      valid_q <= cmd_i.res_load;
      if (cmd_i.q_clear) begin
        chunk_q <= '0;
      end else if (cmd_i.q_step) begin
        chunk_q <= chunk_q + ChunkW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.expand) begin
      cur_q <= rd_q;
      na_q  <= na_c;
      nb_q  <= nb_c;
    end
    if (cmd_i.q_clear) begin
      qset_q <= query_set_i;
      rank_q <= '0;
    end else if (cmd_i.q_step) begin
      rank_q <= rank_d;
    end
    if (cmd_i.res_load) begin
      result_q <= result_d;
    end
  end

  assign status_o.wl_empty   = (count_q == '0);
  assign status_o.chunk_last = (chunk_q == {ChunkW{1'b1}});
  assign result_o            = result_q;
  assign result_valid_o      = valid_q;

endmodule

// File: design/nfa_subset_construction_unit.sv
// Sequence: restart, unknown codes and a step on an empty worklist go from acceptance
// straight to finish; a step runs pop, expand, two push slots and finish; a query runs
// its rank scan, reading the discovered map eight bits per cycle, then finish.
// Throughput: one item at a time; busy falls as the result is loaded, so the next item
// may start in the cycle its strobe is high. Results cannot be stalled.
// Reset: asynchronous, active low; clears control, map, count and configuration at once.
module nfa_subset_construction_unit
  import nsc_pkg::*;
#(
  parameter int unsigned NFA_STATES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Command channel: an item is taken when start is high and busy is low.
  input  logic                 start,
  input  nsc_req_t             cmd_i,
  output logic                 busy,
  // Result channel: one strobe per item, held for exactly one cycle.
  output logic                 result_valid_o,
  output nsc_res_t             result_o,
  // Configuration write port; the user must write it only while the unit is idle, which the unit does not enforce.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TABLE_W-1:0]   cfg_wdata_i
);

  // The controller decodes each item into a short command sequence; the
  // datapath holds all data storage and answers with two status flags.
  nsc_cmd_t    cmd;
  nsc_status_t status;

  nsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (cmd_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // The worklist is a LIFO in a 256-entry memory with a registered read;
  // the discovered map is a flip-flop vector so that restart clears it at once.
  nsc_dpath #(
    .NFA_STATES (NFA_STATES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .query_set_i    (cmd_i.query_set),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

`ifndef NO_ASSERTIONS
  // A result is only presented once the unit has gone idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always makes the unit busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The controller never pops from an empty worklist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.wl_empty)
    else $error("pop issued on empty worklist");

  // The two push slots of a step always follow one another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_a |=> cmd.push_b)
    else $error("push slot sequence broken");
`endif

endmodule
